/* rtl/blum_integer_test_assert.svh */
`ifndef BLUM_INTEGER_TEST_ASSERT_SVH
`define BLUM_INTEGER_TEST_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and switched off while rst_ni is low.
`define BLUM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("blum_integer_test: assertion failed");

// Next-cycle implication, sampled on clk_i and switched off while rst_ni is low.
`define BLUM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("blum_integer_test: assertion failed");

`endif

/* rtl/blum_pkg.sv */
package blum_pkg;

  localparam int unsigned ValueW   = 16;
  localparam int unsigned DivisorW = 9;
  localparam int unsigned SmallW   = 8;
  localparam int unsigned StepW    = 5;
  localparam int unsigned DivCntW  = $clog2(ValueW);

  // Jump conditions of the control word; the jump is taken when the condition holds.
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_D_SQ_GT,
    COND_T_SQ_GT,
    COND_DIV_BUSY,
    COND_REM_ZERO,
    COND_REM_NZ,
    COND_D_NOT3,
    COND_CO_NOT3,
    COND_CO_EQ_D,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    cond_e            cond;
    logic [StepW-1:0] target;
    logic             accept;
    logic             div_start;
    logic             div_x;
    logic             sq_t;
    logic             ld_prime_d;
    logic             ld_prime_co;
    logic             t_inc;
    logic             d_inc;
    logic             set_hit;
    logic             load_out;
  } ctrl_t;

  typedef struct packed {
    logic d_sq_gt;
    logic t_sq_gt;
    logic div_busy;
    logic rem_zero;
    logic d_not3;
    logic co_not3;
    logic co_eq_d;
    logic out_busy;
  } status_t;

  localparam logic [StepW-1:0] STEP_IDLE      = StepW'(0);
  localparam logic [StepW-1:0] STEP_OUTER     = StepW'(1);
  localparam logic [StepW-1:0] STEP_DIV_V     = StepW'(2);
  localparam logic [StepW-1:0] STEP_WAIT_V    = StepW'(3);
  localparam logic [StepW-1:0] STEP_REM_V     = StepW'(4);
  localparam logic [StepW-1:0] STEP_LOAD_D    = StepW'(5);
  localparam logic [StepW-1:0] STEP_PD_TEST   = StepW'(6);
  localparam logic [StepW-1:0] STEP_PD_DIV    = StepW'(7);
  localparam logic [StepW-1:0] STEP_PD_WAIT   = StepW'(8);
  localparam logic [StepW-1:0] STEP_PD_REM    = StepW'(9);
  localparam logic [StepW-1:0] STEP_PD_NEXT   = StepW'(10);
  localparam logic [StepW-1:0] STEP_LOAD_CO   = StepW'(11);
  localparam logic [StepW-1:0] STEP_CO_DIST   = StepW'(12);
  localparam logic [StepW-1:0] STEP_PC_TEST   = StepW'(13);
  localparam logic [StepW-1:0] STEP_PC_DIV    = StepW'(14);
  localparam logic [StepW-1:0] STEP_PC_WAIT   = StepW'(15);
  localparam logic [StepW-1:0] STEP_PC_REM    = StepW'(16);
  localparam logic [StepW-1:0] STEP_PC_NEXT   = StepW'(17);
  localparam logic [StepW-1:0] STEP_HIT       = StepW'(18);
  localparam logic [StepW-1:0] STEP_NEXT_D    = StepW'(19);
  localparam logic [StepW-1:0] STEP_FINISH    = StepW'(20);
  localparam logic [StepW-1:0] STEP_RETURN    = StepW'(21);

  // The microprogram. Actions of a step happen every cycle the step is held.
  function automatic ctrl_t ucode(input logic [StepW-1:0] step);
    ctrl_t w;
    w        = '0;
    w.cond   = COND_NEVER;
    w.target = STEP_IDLE;
    unique case (step)
      STEP_IDLE: begin
        w.accept = 1'b1;
        w.cond   = COND_NO_INPUT;
        w.target = STEP_IDLE;
      end
      STEP_OUTER: begin
        w.cond   = COND_D_SQ_GT;
        w.target = STEP_FINISH;
      end
      STEP_DIV_V: begin
        w.div_start = 1'b1;
      end
      STEP_WAIT_V: begin
        w.cond   = COND_DIV_BUSY;
        w.target = STEP_WAIT_V;
      end
      STEP_REM_V: begin
        w.cond   = COND_REM_NZ;
        w.target = STEP_NEXT_D;
      end
      STEP_LOAD_D: begin
        w.ld_prime_d = 1'b1;
        w.cond       = COND_D_NOT3;
        w.target     = STEP_NEXT_D;
      end
      STEP_PD_TEST: begin
        w.sq_t   = 1'b1;
        w.cond   = COND_T_SQ_GT;
        w.target = STEP_LOAD_CO;
      end
      STEP_PD_DIV: begin
        w.div_start = 1'b1;
        w.div_x     = 1'b1;
      end
      STEP_PD_WAIT: begin
        w.cond   = COND_DIV_BUSY;
        w.target = STEP_PD_WAIT;
      end
      STEP_PD_REM: begin
        w.cond   = COND_REM_ZERO;
        w.target = STEP_NEXT_D;
      end
      STEP_PD_NEXT: begin
        w.t_inc  = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_PD_TEST;
      end
      STEP_LOAD_CO: begin
        w.ld_prime_co = 1'b1;
        w.cond        = COND_CO_NOT3;
        w.target      = STEP_NEXT_D;
      end
      STEP_CO_DIST: begin
        w.cond   = COND_CO_EQ_D;
        w.target = STEP_NEXT_D;
      end
      STEP_PC_TEST: begin
        w.sq_t   = 1'b1;
        w.cond   = COND_T_SQ_GT;
        w.target = STEP_HIT;
      end
      STEP_PC_DIV: begin
        w.div_start = 1'b1;
        w.div_x     = 1'b1;
      end
      STEP_PC_WAIT: begin
        w.cond   = COND_DIV_BUSY;
        w.target = STEP_PC_WAIT;
      end
      STEP_PC_REM: begin
        w.cond   = COND_REM_ZERO;
        w.target = STEP_NEXT_D;
      end
      STEP_PC_NEXT: begin
        w.t_inc  = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_PC_TEST;
      end
      STEP_HIT: begin
        w.set_hit = 1'b1;
        w.cond    = COND_ALWAYS;
        w.target  = STEP_FINISH;
      end
      STEP_NEXT_D: begin
        w.d_inc  = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_OUTER;
      end
      STEP_FINISH: begin
        w.load_out = 1'b1;
        w.cond     = COND_OUT_BUSY;
        w.target   = STEP_FINISH;
      end
      STEP_RETURN: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/blum_integer_test.sv */
// Blum integer test: each input beat carries one value, and one output beat later
// tells whether it is the product of two distinct primes that are both 3 mod 4,
// with the smaller and larger prime (zeros otherwise). Only the low VALUE_WIDTH
// bits of the value count, and never more than 16. One value is worked at a time
// by a microprogrammed sequencer that drives a shared squarer and a restoring
// divider; a trial division starts the divider and waits while it is busy. Values
// below 4 go from the first bound check straight to the output register; the worst
// cases are values with no small factor, where every candidate up to the square
// root of the value is tried by division, plus the primality trials of the
// candidates that divide it. The next input beat is taken only after the result
// is loaded and the sequencer has passed through the return step back to idle,
// even if the output beat has not yet been taken.
module blum_integer_test #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] small_factor, [23:8] large_factor
  output logic        m_axis_tuser    // [0] is_blum
);

  localparam int unsigned VW       = blum_pkg::ValueW;
  localparam int unsigned EffWidth = (VALUE_WIDTH < VW) ? VALUE_WIDTH : VW;
  localparam logic [31:0] MaskWide = (32'd1 << EffWidth) - 32'd1;

  blum_pkg::ctrl_t               ctrl;
  blum_pkg::status_t             status;
  logic [VW-1:0]                 value_masked;
  logic [blum_pkg::SmallW-1:0]   small_factor;
  logic [VW-1:0]                 large_factor;

  assign value_masked = s_axis_tdata & MaskWide[VW-1:0];

  blum_sequencer u_sequencer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .status_i  (status),
    .ctrl_o    (ctrl)
  );

  blum_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .in_valid_i   (s_axis_tvalid),
    .in_value_i   (value_masked),
    .out_ready_i  (m_axis_tready),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid),
    .out_is_blum_o(m_axis_tuser),
    .out_small_o  (small_factor),
    .out_large_o  (large_factor)
  );

  assign s_axis_tready = ctrl.accept;
  assign m_axis_tdata  = {large_factor, small_factor};

endmodule

/* rtl/blum_divider.sv */
module blum_divider (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [blum_pkg::ValueW-1:0]        dividend_i,
  input  logic [blum_pkg::DivisorW-1:0]      divisor_i,
  output logic                               busy_o,
  output logic [blum_pkg::ValueW-1:0]        quotient_o,
  output logic [blum_pkg::DivisorW-1:0]      remainder_o
);

  localparam int unsigned VW = blum_pkg::ValueW;
  localparam int unsigned DW = blum_pkg::DivisorW;
  localparam int unsigned CW = blum_pkg::DivCntW;

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] div_q, div_d;
  logic [DW:0]   trial;
  logic          fits;

  // Restoring division, one quotient bit per cycle; the dividend shifts out of
  // the quotient register from the top while quotient bits enter at the bottom.
  assign trial = {rem_q, quo_q[VW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[VW-2:0], fits};
      rem_d = fits ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(VW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* rtl/blum_datapath.sv */
module blum_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  blum_pkg::ctrl_t                ctrl_i,
  input  logic                           in_valid_i,
  input  logic [blum_pkg::ValueW-1:0]    in_value_i,
  input  logic                           out_ready_i,
  output blum_pkg::status_t              status_o,
  output logic                           out_valid_o,
  output logic                           out_is_blum_o,
  output logic [blum_pkg::SmallW-1:0]    out_small_o,
  output logic [blum_pkg::ValueW-1:0]    out_large_o
);

  localparam int unsigned VW = blum_pkg::ValueW;
  localparam int unsigned DW = blum_pkg::DivisorW;
  localparam int unsigned SW = blum_pkg::SmallW;

  logic [VW-1:0]   v_q, x_q, co_q, hi_q;
  logic [DW-1:0]   d_q, t_q;
  logic [SW-1:0]   lo_q;
  logic            hit_q;
  logic            out_valid_q;
  logic            out_is_blum_q;
  logic [SW-1:0]   out_small_q;
  logic [VW-1:0]   out_large_q;

  logic [DW-1:0]   sq_op;
  logic [2*DW-1:0] sq;
  logic [VW-1:0]   sq_ref;
  logic            sq_gt;
  logic            div_busy;
  logic [VW-1:0]   quotient;
  logic [DW-1:0]   remainder;
  logic            out_busy;
  logic            load_out;

  // One shared squarer serves both loop bounds: d*d against the value and
  // t*t against the number under primality test.
  assign sq_op  = ctrl_i.sq_t ? t_q : d_q;
  assign sq_ref = ctrl_i.sq_t ? x_q : v_q;
  assign sq     = sq_op * sq_op;
  assign sq_gt  = sq > {{(2*DW-VW){1'b0}}, sq_ref};

  blum_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (ctrl_i.div_x ? x_q : v_q),
    .divisor_i  (ctrl_i.div_x ? t_q : d_q),
    .busy_o     (div_busy),
    .quotient_o (quotient),
    .remainder_o(remainder)
  );

  assign out_busy = out_valid_q && !out_ready_i;
  assign load_out = ctrl_i.load_out && !out_busy;

  always_comb begin
    status_o          = '0;
    status_o.d_sq_gt  = sq_gt;
    status_o.t_sq_gt  = sq_gt;
    status_o.div_busy = div_busy;
    status_o.rem_zero = remainder == '0;
    status_o.d_not3   = d_q[1:0] != 2'b11;
    status_o.co_not3  = co_q[1:0] != 2'b11;
    status_o.co_eq_d  = co_q == {{(VW-DW){1'b0}}, d_q};
    status_o.out_busy = out_busy;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept && in_valid_i) begin
      v_q   <= in_value_i;
      d_q   <= DW'(2);
      hit_q <= 1'b0;
      lo_q  <= '0;
      hi_q  <= '0;
    end
    if (ctrl_i.d_inc) begin
      d_q <= d_q + DW'(1);
    end
    if (ctrl_i.ld_prime_d) begin
      x_q  <= {{(VW-DW){1'b0}}, d_q};
      co_q <= quotient;
      t_q  <= DW'(2);
    end
    if (ctrl_i.ld_prime_co) begin
      x_q <= co_q;
      t_q <= DW'(2);
    end
    if (ctrl_i.t_inc) begin
      t_q <= t_q + DW'(1);
    end
    if (ctrl_i.set_hit) begin
      hit_q <= 1'b1;
      lo_q  <= d_q[SW-1:0];
      hi_q  <= co_q;
    end
    if (load_out) begin
      out_is_blum_q <= hit_q;
      out_small_q   <= lo_q;
      out_large_q   <= hi_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_is_blum_o = out_is_blum_q;
  assign out_small_o   = out_small_q;
  assign out_large_o   = out_large_q;

endmodule

/* rtl/blum_sequencer.sv */
module blum_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  blum_pkg::status_t status_i,
  output blum_pkg::ctrl_t   ctrl_o
);

  localparam int unsigned SW = blum_pkg::StepW;

  logic [SW-1:0]   step_q, step_d;
  blum_pkg::ctrl_t ctrl;
  logic            take;

  assign ctrl = blum_pkg::ucode(step_q);

  always_comb begin
    unique case (ctrl.cond)
      blum_pkg::COND_NEVER:    take = 1'b0;
      blum_pkg::COND_ALWAYS:   take = 1'b1;
      blum_pkg::COND_NO_INPUT: take = !in_valid_i;
      blum_pkg::COND_D_SQ_GT:  take = status_i.d_sq_gt;
      blum_pkg::COND_T_SQ_GT:  take = status_i.t_sq_gt;
      blum_pkg::COND_DIV_BUSY: take = status_i.div_busy;
      blum_pkg::COND_REM_ZERO: take = status_i.rem_zero;
      blum_pkg::COND_REM_NZ:   take = !status_i.rem_zero;
      blum_pkg::COND_D_NOT3:   take = status_i.d_not3;
      blum_pkg::COND_CO_NOT3:  take = status_i.co_not3;
      blum_pkg::COND_CO_EQ_D:  take = status_i.co_eq_d;
      blum_pkg::COND_OUT_BUSY: take = status_i.out_busy;
      default:                 take = 1'b1;
    endcase
    step_d = take ? ctrl.target : step_q + SW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= blum_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

/* rtl/blum_checker.sv */
`include "blum_integer_test_assert.svh"

module blum_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  logic [7:0]  small_factor;
  logic [15:0] large_factor;
  logic        in_beat;

  assign small_factor = m_axis_tdata[7:0];
  assign large_factor = m_axis_tdata[23:8];
  assign in_beat      = s_axis_tvalid && s_axis_tready;

  // A stalled result beat keeps its contents.
  `BLUM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // A value that is not a Blum integer reports zero factors.
  `BLUM_ASSERT_NOW(a_no_hit_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 24'd0)

  // A hit carries two distinct factors, both 3 mod 4, the smaller first.
  `BLUM_ASSERT_NOW(a_hit_factors, m_axis_tvalid && m_axis_tuser,
    small_factor[1:0] == 2'b11 && large_factor[1:0] == 2'b11 &&
    {8'd0, small_factor} < large_factor)

  // Only one value is in work at a time: an input beat closes the input side.
  `BLUM_ASSERT_NEXT(a_one_in_flight, in_beat, !s_axis_tready)

endmodule

bind blum_integer_test blum_checker u_blum_checker (.*);
